// ===== hdl/uer_pkg.sv =====
// shared widths, reset values and control/status types for the echo ranger
// used by uer_div, uer_ctrl, uer_datapath and ultrasonic_echo_ranger_unit
`default_nettype none
package uer_pkg;

  localparam int TRIG_W   = 10;
  localparam int PERIOD_W = 16;
  localparam int SAMPLE_W = 8;
  localparam int OFFSET_W = 13;
  localparam int DIST_W   = 15;
  localparam int SUM_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int COUNT_WIDTH_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 2'd3;

  localparam logic [TRIG_W-1:0]   TRIG_TICKS_RST   = 10'd10;
  localparam logic [PERIOD_W-1:0] TIMER_PERIOD_RST = 16'd50000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_COUNT_RST = 8'd100;
  localparam logic [OFFSET_W-1:0] OFFSET_RST       = 13'd90;

  // per-sample term is floor(count * TERM_MUL / TERM_DIV)
  localparam int TERM_MUL = 10;
  localparam int TERM_DIV = 58;

  typedef struct packed {
    logic burst_start;
    logic trig_clear;
    logic trig_inc;
    logic echo_clear;
    logic echo_step;
    logic sample_close;
    logic div_start;
    logic dist_load;
    logic dist_sel;
  } uer_cmd_t;

  typedef struct packed {
    logic trig_reached;
    logic sample_last;
    logic div_done;
  } uer_stat_t;

endpackage
`default_nettype wire

// ===== hdl/uer_div.sv =====
// restoring divider, one quotient bit per cycle, for the burst average
// depends on uer_pkg
`default_nettype none
module uer_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [uer_pkg::SUM_W-1:0]    dividend,
  input  wire logic [uer_pkg::SAMPLE_W-1:0] divisor,
  output logic      [uer_pkg::SUM_W-1:0]    quotient,
  output logic                              done
);
  import uer_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic                running;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] den;
  logic [SAMPLE_W-1:0] rem;
  logic [SUM_W-1:0]    quo;
  logic [SAMPLE_W:0]   shifted;
  logic                fits;

  assign shifted  = {rem, quo[SUM_W-1]};
  assign fits     = shifted >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      step    <= '0;
    end else if (running) begin
      step <= step + 1'b1;
      if (step == STEP_W'(SUM_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (running) begin
      if (fits) begin
        rem <= SAMPLE_W'(shifted - {1'b0, den});
      end else begin
        rem <= shifted[SAMPLE_W-1:0];
      end
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/uer_ctrl.sv =====
// controller: burst phase, handshakes and the flag fields of the result register
// depends on uer_pkg; drives uer_datapath through uer_cmd_t
`default_nettype none
module uer_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic               echo_level,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    trigger_level,
  output logic                    done_res,
  output logic                    busy_res,
  output uer_pkg::uer_cmd_t       cmd,
  input  wire uer_pkg::uer_stat_t stat
);
  import uer_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_TRIG  = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;
  localparam logic [1:0] PH_COUNT = 2'd3;

  localparam logic M_RUN = 1'b0;
  localparam logic M_DIV = 1'b1;

  logic [1:0] phase, phase_next;
  logic       mode, mode_next;
  logic       out_valid_next, trigger_next, done_next, busy_next;
  logic       accept;

  assign in_ready = (mode == M_RUN) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    phase_next     = phase;
    mode_next      = mode;
    out_valid_next = out_valid;
    trigger_next   = trigger_level;
    done_next      = done_res;
    busy_next      = busy_res;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    if (accept) begin
      if (action) begin
        cmd.burst_start = 1'b1;
        phase_next      = PH_TRIG;
      end else begin
        case (phase)
          PH_TRIG: begin
            cmd.trig_inc = 1'b1;
            if (stat.trig_reached) begin
              phase_next = PH_WAIT;
            end
          end
          PH_WAIT: begin
            if (echo_level) begin
              cmd.echo_clear = 1'b1;
              phase_next     = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (echo_level) begin
              cmd.echo_step = 1'b1;
            end else begin
              cmd.sample_close = 1'b1;
              if (stat.sample_last) begin
                cmd.div_start = 1'b1;
                phase_next    = PH_IDLE;
                mode_next     = M_DIV;
              end else begin
                cmd.trig_clear = 1'b1;
                phase_next     = PH_TRIG;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      if (!cmd.div_start) begin
        out_valid_next = 1'b1;
        trigger_next   = (phase_next == PH_TRIG);
        busy_next      = (phase_next != PH_IDLE);
        done_next      = 1'b0;
        cmd.dist_load  = 1'b1;
        cmd.dist_sel   = 1'b0;
      end
    end else if (mode == M_DIV && stat.div_done) begin
      // average ready: slot is empty since the closing transfer loaded nothing
      out_valid_next = 1'b1;
      trigger_next   = 1'b0;
      busy_next      = 1'b0;
      done_next      = 1'b1;
      cmd.dist_load  = 1'b1;
      cmd.dist_sel   = 1'b1;
      mode_next      = M_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      mode          <= M_RUN;
      out_valid     <= 1'b0;
      trigger_level <= 1'b0;
      done_res      <= 1'b0;
      busy_res      <= 1'b0;
    end else begin
      phase         <= phase_next;
      mode          <= mode_next;
      out_valid     <= out_valid_next;
      trigger_level <= trigger_next;
      done_res      <= done_next;
      busy_res      <= busy_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/uer_datapath.sv =====
// datapath: config registers, trigger and echo counters, running sum, divider
// depends on uer_pkg and uer_div
`default_nettype none
module uer_datapath #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire uer_pkg::uer_cmd_t              cmd,
  output uer_pkg::uer_stat_t                  stat,
  output logic signed [uer_pkg::DIST_W-1:0]   distance
);
  import uer_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
  localparam int REM_W = $clog2(TERM_DIV);

  logic [TRIG_W-1:0]   trigger_ticks;
  logic [PERIOD_W-1:0] timer_period;
  logic [SAMPLE_W-1:0] sample_count;
  logic [OFFSET_W-1:0] offset;

  logic [TRIG_W-1:0]      trig_cnt, trig_inc, tt;
  logic [COUNT_WIDTH-1:0] echo_cnt;
  logic [COUNT_WIDTH-1:0] term_q;
  logic [REM_W-1:0]       term_r;
  logic [REM_W:0]         r_add;
  logic                   echo_wrap;
  logic [SAMPLE_W-1:0]    samples_done, samples_inc, n;
  logic [SUM_W-1:0]       distance_sum, sum_next, term;
  logic [COUNT_WIDTH+SUM_W-1:0] q_wide;
  logic [SUM_W-1:0]       avg;
  logic                   div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= TRIG_TICKS_RST;
      timer_period  <= TIMER_PERIOD_RST;
      sample_count  <= SAMPLE_COUNT_RST;
      offset        <= OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIG_TICKS:   trigger_ticks <= cfg_data[TRIG_W-1:0];
        REG_TIMER_PERIOD: timer_period  <= cfg_data[PERIOD_W-1:0];
        REG_SAMPLE_COUNT: sample_count  <= cfg_data[SAMPLE_W-1:0];
        REG_OFFSET:       offset        <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // zero trigger length and zero sample count act as one
  assign tt          = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;
  assign n           = (sample_count == '0) ? SAMPLE_W'(1) : sample_count;
  assign trig_inc    = trig_cnt + 1'b1;
  assign samples_inc = samples_done + 1'b1;

  // term kept as quotient/remainder of count*10 by 58, updated per count step
  assign echo_wrap = (CMP_W'(echo_cnt) >= CMP_W'(timer_period)) || (echo_cnt == '1);
  assign r_add     = (REM_W+1)'(term_r) + (REM_W+1)'(TERM_MUL);
  assign q_wide    = {{SUM_W{1'b0}}, term_q};
  assign term      = q_wide[SUM_W-1:0];
  assign sum_next  = distance_sum + term;

  assign stat.trig_reached = trig_inc >= tt;
  assign stat.sample_last  = samples_inc >= n;
  assign stat.div_done     = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_cnt     <= '0;
      echo_cnt     <= '0;
      term_q       <= '0;
      term_r       <= '0;
      samples_done <= '0;
      distance_sum <= '0;
    end else begin
      if (cmd.burst_start || cmd.trig_clear) begin
        trig_cnt <= '0;
      end else if (cmd.trig_inc) begin
        trig_cnt <= trig_inc;
      end

      if (cmd.burst_start || cmd.echo_clear || (cmd.echo_step && echo_wrap)) begin
        echo_cnt <= '0;
        term_q   <= '0;
        term_r   <= '0;
      end else if (cmd.echo_step) begin
        echo_cnt <= echo_cnt + 1'b1;
        if (r_add >= (REM_W+1)'(TERM_DIV)) begin
          term_r <= REM_W'(r_add - (REM_W+1)'(TERM_DIV));
          term_q <= term_q + 1'b1;
        end else begin
          term_r <= r_add[REM_W-1:0];
        end
      end

      if (cmd.burst_start) begin
        samples_done <= '0;
        distance_sum <= '0;
      end else if (cmd.sample_close) begin
        samples_done <= samples_inc;
        distance_sum <= sum_next;
      end
    end
  end

  uer_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_next),
    .divisor  (n),
    .quotient (avg),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.dist_load) begin
      if (cmd.dist_sel) begin
        distance <= avg[DIST_W-1:0] - DIST_W'(offset);
      end else begin
        distance <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ultrasonic_echo_ranger_unit.sv =====
// top level of the ultrasonic echo ranger: controller plus datapath
// depends on uer_pkg, uer_ctrl, uer_datapath (and uer_div below it)
//
// usage: each input transfer is one timer tick (action 0) or a burst start
// (action 1), with the echo pin level for that tick. every input transfer
// gives exactly one result transfer with the trigger pin level, busy flag,
// and on the tick that closes the last sample a done flag and the signed
// averaged distance minus offset (distance is 0 otherwise).
// an ordinary tick's result is registered and shown in the next cycle, so
// ticks can stream at one per clock while out_ready stays high; the tick
// that closes a burst runs the 24-step restoring divider for the average
// and loads its result when the divider is done, with in_ready low meanwhile.
// the result register holds one item; when the receiver stalls, in_ready
// drops until that item is taken, and nothing is lost.
// configuration writes use index 0..3 = trigger_ticks,
// timer_period, sample_count, offset.
// reset (rst, synchronous) restores register defaults, idles the burst
// controller, clears all counters and empties the result register.
`default_nettype none
module ultrasonic_echo_ranger_unit #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           action,
  input  wire logic                           echo_level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                trigger_level,
  output logic                                done_res,
  output logic signed [uer_pkg::DIST_W-1:0]   distance,
  output logic                                busy_res
);
  import uer_pkg::*;

  uer_cmd_t  cmd;
  uer_stat_t stat;

  uer_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .echo_level    (echo_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_level (trigger_level),
    .done_res      (done_res),
    .busy_res      (busy_res),
    .cmd           (cmd),
    .stat          (stat)
  );

  uer_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .distance  (distance)
  );

endmodule
`default_nettype wire
